[rtl/mm_pkg.sv]
package mm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ACT_W     = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 32;
    localparam int DIM_REG_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // Saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Tag that travels with each multiply-accumulate term
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             done;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

[rtl/mm_ram.sv]
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while the read enable is low
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/matrix_multiply.sv]
// Dense matrix multiply, C = A x B, signed fixed point with FRAC_BITS fraction bits.
//
// Input channel (i_in_valid / o_in_stall): each request carries an action, a row,
// a column and a value. A load of A or B writes one element into its on-chip RAM and
// frees the input; loads outside the configured dimensions are dropped, action 3 too.
// A compute request walks all rows_a x cols_b result elements in row-major order.
// Output channel (o_out_valid / i_out_stall): one request per result element with
// its row, column, rounded and saturated value, and o_out_last on the final one.
// Timing: one multiply-accumulate per cycle while the output is not stalled, set
// by the single read port of each RAM. A compute occupies the input side until
// its last term has issued. Pipeline: RAM read, multiply, accumulate, round/saturate.
// A stall on the output freezes the whole pipeline; the held result stays put.
// Loads and the next compute are taken as soon as the previous compute has issued
// its last term, even while results still wait in the pipeline.
// Reset (synchronous, active low) empties the pipeline and sets all three dimension
// registers to 8; RAM contents are not cleared and must be loaded before use.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 rows_a,
// 1 inner_dim, 2 cols_b); write only while the block is idle.
module matrix_multiply import mm_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [ACT_W-1:0]        i_action,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_elem_value,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_out_last,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DIM_REG_W-1:0]    i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + CW + 1;
    // rounding constant: half an LSB of the result, zero with no fraction bits
    localparam logic signed [ACC_W-1:0] RND = ACC_W'((2 ** FRAC_BITS) / 2);

    // dimension register clamped to 1..MAX_DIM
    function automatic logic [DW-1:0] f_dim(input logic [DIM_REG_W-1:0] reg_val);
        if (reg_val == '0) begin
            return DW'(1);
        end else if (int'(reg_val) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(reg_val);
        end
    endfunction

    // configuration
    logic [DIM_REG_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic [DW-1:0]        dim_m, dim_k, dim_n;

    assign dim_m = f_dim(r_rows_a);
    assign dim_k = f_dim(r_inner_dim);
    assign dim_n = f_dim(r_cols_b);

    // sequencer
    t_seq_state    r_state, n_state;
    logic [CW-1:0] r_i, r_j, r_t;
    logic [CW-1:0] n_i, n_j, n_t;
    logic          in_acc, cmp_acc, ld_a, ld_b, issue, adv;
    logic          t_last, j_last, i_last;
    logic [AW-1:0] waddr, a_raddr, b_raddr;

    // pipeline
    t_tag                     n_s1, r_s1, r_s2, r_s3, n_s3;
    logic signed [VAL_W-1:0]  a_rdata, b_rdata;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, acc_next, r_sum, rounded;
    logic [ACC_W-VAL_W:0]     hi_bits;
    logic [VAL_W-1:0]         sat_val;

    logic                     r_out_valid, r_out_last;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic signed [VAL_W-1:0]  r_out_value;

    // whole pipeline moves unless a held result is stalled
    assign adv = !r_out_valid || !i_out_stall;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign cmp_acc = in_acc && (i_action == ACT_COMPUTE);
    assign ld_a    = in_acc && (i_action == ACT_LOAD_A)
                     && (i_row_index < dim_m) && (i_col_index < dim_k);
    assign ld_b    = in_acc && (i_action == ACT_LOAD_B)
                     && (i_row_index < dim_k) && (i_col_index < dim_n);

    assign waddr   = AW'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign a_raddr = AW'(int'(r_i) * MAX_DIM + int'(r_t));
    assign b_raddr = AW'(int'(r_t) * MAX_DIM + int'(r_j));

    assign t_last = (DW'(r_t) == dim_k - DW'(1));
    assign j_last = (DW'(r_j) == dim_n - DW'(1));
    assign i_last = (DW'(r_i) == dim_m - DW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (cmp_acc) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (adv && t_last && j_last && i_last) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // sequencer outputs: stall, term issue, loop counters
    always_comb begin
        o_in_stall = (r_state != SEQ_IDLE);
        issue      = (r_state == SEQ_RUN) && adv;
        n_i        = r_i;
        n_j        = r_j;
        n_t        = r_t;
        if (cmp_acc) begin
            n_i = '0;
            n_j = '0;
            n_t = '0;
        end else if (issue) begin
            if (t_last) begin
                n_t = '0;
                if (j_last) begin
                    n_j = '0;
                    n_i = i_last ? '0 : r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
            end else begin
                n_t = r_t + CW'(1);
            end
        end
        n_s1.vld   = issue;
        n_s1.first = (r_t == '0);
        n_s1.last  = t_last;
        n_s1.done  = t_last && j_last && i_last;
        n_s1.row   = IDX_W'(r_i);
        n_s1.col   = IDX_W'(r_j);
    end

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ld_a),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_re    (issue),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ld_b),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_re    (issue),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // accumulate; first term of an element restarts the sum
    assign acc_next = (r_s2.first ? '0 : r_acc) + ACC_W'(r_prod);

    always_comb begin
        n_s3     = r_s2;
        n_s3.vld = r_s2.vld && r_s2.last;
    end

    // round half up, then saturate to 32 bits
    assign rounded = (r_sum + RND) >>> FRAC_BITS;
    assign hi_bits = rounded[ACC_W-1:VAL_W-1];

    always_comb begin
        if ((&hi_bits) || !(|hi_bits)) begin
            sat_val = rounded[VAL_W-1:0];
        end else begin
            sat_val = rounded[ACC_W-1] ? VAL_MIN : VAL_MAX;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_t         <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_out_valid <= 1'b0;
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_t     <= n_t;
            if (adv) begin
                r_s1        <= n_s1;
                r_s2        <= r_s1;
                r_s3        <= n_s3;
                r_out_valid <= r_s3.vld;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                    CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                    CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= a_rdata * b_rdata;
            if (r_s2.vld) begin
                r_acc <= acc_next;
                r_sum <= acc_next;
            end
            r_out_row   <= r_s3.row;
            r_out_col   <= r_s3.col;
            r_out_last  <= r_s3.done;
            r_out_value <= sat_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

[rtl/mm_chk.sv]
module mm_chk import mm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [ACT_W-1:0]        i_action,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [IDX_W-1:0]        o_out_row,
    input logic [IDX_W-1:0]        o_out_col,
    input logic signed [VAL_W-1:0] o_out_value,
    input logic                    o_out_last
);

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a compute request holds off further requests
    a_cmp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_COMPUTE) |=> o_in_stall)
        else $error("request taken during compute");

    // after a load the input is not stalled in the next cycle
    a_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_LOAD_A || i_action == ACT_LOAD_B))
        |=> !o_in_stall)
        else $error("load left input stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_value)
        && $stable(o_out_row) && $stable(o_out_col) && $stable(o_out_last)))
        else $error("stalled result changed");

endmodule

bind matrix_multiply mm_chk u_mm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_value (o_out_value),
    .o_out_last  (o_out_last)
);
